### design/mdc_pkg.sv
// Shared types, constants and helper functions for the method dispatch cache.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package mdc_pkg;

    localparam int ENTRIES  = 1024;
    localparam int REF_BITS = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = IDX_W + 1;
    localparam int TAG_W    = 2 * REF_BITS;

    // Stream packing: operation, receiver, class, selector, closure from bit 0 up.
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_BITS     = OP_W + 4 * REF_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + 2 * REF_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = REF_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_NIL_CLASS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_CLASS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT     = 2'd0,
        STAT_MISS    = 2'd1,
        STAT_NOCLASS = 2'd2,
        STAT_DONE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_LOOKUP = 2'd2,
        S_SWEEP  = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        OUT_IMM    = 2'd0,
        OUT_LOOKUP = 2'd1,
        OUT_FLUSH  = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     accept;
        logic     lookup_rd;
        logic     fill_we;
        logic     sweep_start;
        logic     sweep_step;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cls_zero;
        logic            sweep_done;
    } t_sts;

    function automatic logic [IDX_W-1:0] entry_index(
        input logic [REF_BITS-1:0] cls,
        input logic [REF_BITS-1:0] sel
    );
        logic [REF_BITS-1:0] h;
        h = (cls << 2) ^ (sel >> 3);
        return h[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/mdc_ctrl.sv
// Controller state machine of the method dispatch cache.
// Depends on mdc_pkg; drives the datapath only through t_cmd and reads t_sts.
`default_nettype none

module mdc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  mdc_pkg::t_sts       i_sts,
    output mdc_pkg::t_cmd       o_cmd
);

    mdc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;

    // A request is taken only when the output register is free at this edge.
    assign o_in_ready  = (r_state == mdc_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdc_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            mdc_pkg::S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = mdc_pkg::S_IDLE;
                end
            end
            mdc_pkg::S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.op)
                        mdc_pkg::OP_LOOKUP: begin
                            if (i_sts.cls_zero) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_sel  = mdc_pkg::OUT_IMM;
                            end else begin
                                o_cmd.lookup_rd = 1'b1;
                                n_state         = mdc_pkg::S_LOOKUP;
                            end
                        end
                        mdc_pkg::OP_FILL: begin
                            o_cmd.fill_we  = !i_sts.cls_zero;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = mdc_pkg::OUT_IMM;
                        end
                        mdc_pkg::OP_FLUSH: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = mdc_pkg::S_SWEEP;
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = mdc_pkg::OUT_IMM;
                        end
                    endcase
                end
            end
            mdc_pkg::S_LOOKUP: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel  = mdc_pkg::OUT_LOOKUP;
                n_state        = mdc_pkg::S_IDLE;
            end
            mdc_pkg::S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = mdc_pkg::OUT_FLUSH;
                    n_state        = mdc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdc_pkg::S_CLEAR;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

`default_nettype wire

### design/mdc_dp.sv
// Datapath of the method dispatch cache: class registers, tag and closure
// memories, sweep counter and result register. Depends on mdc_pkg.
`default_nettype none

module mdc_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  mdc_pkg::t_cmd                      i_cmd,
    output mdc_pkg::t_sts                      o_sts,
    input  wire                                i_cfg_we,
    input  wire  [mdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [mdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire  [mdc_pkg::OP_W-1:0]           i_op,
    input  wire  [mdc_pkg::REF_BITS-1:0]       i_recv,
    input  wire  [mdc_pkg::REF_BITS-1:0]       i_cls,
    input  wire  [mdc_pkg::REF_BITS-1:0]       i_sel,
    input  wire  [mdc_pkg::REF_BITS-1:0]       i_clo,
    output logic [mdc_pkg::STATUS_W-1:0]       o_status,
    output logic [mdc_pkg::REF_BITS-1:0]       o_closure,
    output logic [mdc_pkg::REF_BITS-1:0]       o_resolved
);

    // Each tag word holds the selector tag above the class tag.
    logic [mdc_pkg::TAG_W-1:0]    tag_mem [mdc_pkg::ENTRIES];
    logic [mdc_pkg::REF_BITS-1:0] clo_mem [mdc_pkg::ENTRIES];

    logic [mdc_pkg::REF_BITS-1:0] r_nil_class, r_tag_class;
    logic [mdc_pkg::REF_BITS-1:0] r_req_cls, r_req_sel;
    logic [mdc_pkg::TAG_W-1:0]    r_tag_rd;
    logic [mdc_pkg::REF_BITS-1:0] r_clo_rd;

    logic [mdc_pkg::CNT_W-1:0]    r_sweep_cnt;
    logic [mdc_pkg::IDX_W-1:0]    r_sweep_prev;
    logic                         r_sweep_prev_vld;
    logic                         r_sweep_all;
    logic [mdc_pkg::REF_BITS-1:0] r_sweep_sel;

    logic [mdc_pkg::STATUS_W-1:0] r_out_status;
    logic [mdc_pkg::REF_BITS-1:0] r_out_closure, r_out_cls;

    logic [mdc_pkg::REF_BITS-1:0] w_cls;
    logic                         w_cls_zero;
    logic [mdc_pkg::IDX_W-1:0]    w_idx;
    logic                         w_sweep_done;
    logic                         w_sweep_rd;
    logic                         w_sweep_wr;
    logic                         w_tag_re, w_tag_we;
    logic [mdc_pkg::IDX_W-1:0]    w_tag_raddr, w_tag_waddr;
    logic [mdc_pkg::TAG_W-1:0]    w_tag_wdata;
    logic                         w_hit;
    logic [mdc_pkg::STATUS_W-1:0] w_imm_status;
    logic [mdc_pkg::REF_BITS-1:0] w_imm_cls;
    logic                         w_op_uses_class;

    // Class resolution: nil receiver, tagged receiver, or the supplied class word.
    always_comb begin
        if (i_recv == '0) begin
            w_cls = r_nil_class;
        end else if (i_recv[0]) begin
            w_cls = r_tag_class;
        end else begin
            w_cls = i_cls;
        end
    end

    assign w_cls_zero = (w_cls == '0);
    assign w_idx      = mdc_pkg::entry_index(w_cls, i_sel);

    assign w_sweep_done = r_sweep_cnt[mdc_pkg::IDX_W];
    assign w_sweep_rd   = i_cmd.sweep_step && !w_sweep_done;
    assign w_sweep_wr   = i_cmd.sweep_step && r_sweep_prev_vld &&
                          (r_sweep_all ||
                           (r_tag_rd[mdc_pkg::TAG_W-1:mdc_pkg::REF_BITS] == r_sweep_sel));

    assign w_tag_re    = i_cmd.lookup_rd || w_sweep_rd;
    assign w_tag_raddr = i_cmd.lookup_rd ? w_idx : r_sweep_cnt[mdc_pkg::IDX_W-1:0];
    assign w_tag_we    = i_cmd.fill_we || w_sweep_wr;
    assign w_tag_waddr = i_cmd.fill_we ? w_idx : r_sweep_prev;
    assign w_tag_wdata = i_cmd.fill_we ? {i_sel, w_cls} : '0;

    assign o_sts.op         = i_op;
    assign o_sts.cls_zero   = w_cls_zero;
    assign o_sts.sweep_done = w_sweep_done;

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            tag_mem[w_tag_waddr] <= w_tag_wdata;
        end
        if (w_tag_re) begin
            r_tag_rd <= tag_mem[w_tag_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_we) begin
            clo_mem[w_idx] <= i_clo;
        end
        if (i_cmd.lookup_rd) begin
            r_clo_rd <= clo_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nil_class <= '0;
            r_tag_class <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mdc_pkg::CFG_NIL_CLASS: r_nil_class <= i_cfg_data;
                mdc_pkg::CFG_TAG_CLASS: r_tag_class <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The sweep reads one entry per cycle and clears the entry read the cycle
    // before, if all entries are to be cleared or that entry's selector tag matches.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt      <= '0;
            r_sweep_prev_vld <= 1'b0;
            r_sweep_all      <= 1'b1;
        end else if (i_cmd.sweep_start) begin
            r_sweep_cnt      <= '0;
            r_sweep_prev_vld <= 1'b0;
            r_sweep_all      <= (i_sel == '0);
        end else if (i_cmd.sweep_step) begin
            r_sweep_prev_vld <= !w_sweep_done;
            if (!w_sweep_done) begin
                r_sweep_cnt <= r_sweep_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_sweep_sel <= i_sel;
        end
        if (w_sweep_rd) begin
            r_sweep_prev <= r_sweep_cnt[mdc_pkg::IDX_W-1:0];
        end
        if (i_cmd.accept) begin
            r_req_cls <= w_cls;
            r_req_sel <= i_sel;
        end
    end

    assign w_hit = (r_tag_rd[mdc_pkg::REF_BITS-1:0] == r_req_cls) &&
                   (r_tag_rd[mdc_pkg::TAG_W-1:mdc_pkg::REF_BITS] == r_req_sel);

    assign w_op_uses_class = (i_op == mdc_pkg::OP_LOOKUP) || (i_op == mdc_pkg::OP_FILL);
    assign w_imm_status    = (w_op_uses_class && w_cls_zero) ? mdc_pkg::STAT_NOCLASS
                                                             : mdc_pkg::STAT_DONE;
    assign w_imm_cls       = w_op_uses_class ? w_cls : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                mdc_pkg::OUT_IMM: begin
                    r_out_status  <= w_imm_status;
                    r_out_closure <= '0;
                    r_out_cls     <= w_imm_cls;
                end
                mdc_pkg::OUT_LOOKUP: begin
                    r_out_status  <= w_hit ? mdc_pkg::STAT_HIT : mdc_pkg::STAT_MISS;
                    r_out_closure <= w_hit ? r_clo_rd : '0;
                    r_out_cls     <= r_req_cls;
                end
                default: begin
                    r_out_status  <= mdc_pkg::STAT_DONE;
                    r_out_closure <= '0;
                    r_out_cls     <= '0;
                end
            endcase
        end
    end

    assign o_status   = r_out_status;
    assign o_closure  = r_out_closure;
    assign o_resolved = r_out_cls;

endmodule

`default_nettype wire

### design/method_dispatch_cache.sv
// Top level of the method dispatch cache: stream ports, field packing, and
// the controller and datapath instances. Depends on mdc_pkg, mdc_ctrl, mdc_dp.
//
// Direct-mapped message-send cache with ENTRIES entries, indexed by
// ((class << 2) ^ (selector >> 3)) masked to the entry count. A fill, a
// lookup whose class resolves to zero, and operation code three each load
// their result on acceptance. A lookup registers the read of the tag and
// closure memories and then loads its result, and no request is taken
// until that result is loaded. A flush walks the tag memory one entry per
// cycle with one read and one write port and loads its result when the walk
// is done. After reset the same walk clears the tags, and no request is
// taken until it is done; configuration writes are taken at any time. A
// request is taken while the previous result is still in the output
// register if that result is being taken in the same cycle.
`default_nettype none

module method_dispatch_cache (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // s_tdata, from bit 0: operation, receiver_ref, class_ref, selector_ref,
    // closure_in, zero fill.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [mdc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata, from bit 0: status, closure_out, resolved_class, zero fill.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [mdc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  wire                                 i_cfg_we,
    input  wire  [mdc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [mdc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int RB     = mdc_pkg::REF_BITS;
    localparam int OFS_RX = mdc_pkg::OP_W;
    localparam int OFS_CL = OFS_RX + RB;
    localparam int OFS_SL = OFS_CL + RB;
    localparam int OFS_CO = OFS_SL + RB;
    localparam int OFS_OC = mdc_pkg::STATUS_W;
    localparam int OFS_OR = OFS_OC + RB;

    mdc_pkg::t_cmd w_cmd;
    mdc_pkg::t_sts w_sts;

    logic [mdc_pkg::STATUS_W-1:0] w_status;
    logic [RB-1:0]                w_closure;
    logic [RB-1:0]                w_resolved;

    mdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mdc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (s_tdata[mdc_pkg::OP_W-1:0]),
        .i_recv     (s_tdata[OFS_RX +: RB]),
        .i_cls      (s_tdata[OFS_CL +: RB]),
        .i_sel      (s_tdata[OFS_SL +: RB]),
        .i_clo      (s_tdata[OFS_CO +: RB]),
        .o_status   (w_status),
        .o_closure  (w_closure),
        .o_resolved (w_resolved)
    );

    always_comb begin
        m_tdata                            = '0;
        m_tdata[mdc_pkg::STATUS_W-1:0]     = w_status;
        m_tdata[OFS_OC +: RB]              = w_closure;
        m_tdata[OFS_OR +: RB]              = w_resolved;
    end

endmodule

`default_nettype wire

### design/mdc_chk.sv
// Port-level checker for the method dispatch cache, bound to the top level.
// Depends on mdc_pkg for field widths and status codes.
`default_nettype none

module mdc_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire [mdc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [mdc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input wire                              i_cfg_we,
    input wire [mdc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input wire [mdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int RB = mdc_pkg::REF_BITS;
    localparam int SW = mdc_pkg::STATUS_W;

    logic [SW-1:0] w_status;
    logic [RB-1:0] w_closure;
    logic [RB-1:0] w_resolved;

    assign w_status   = m_tdata[SW-1:0];
    assign w_closure  = m_tdata[SW +: RB];
    assign w_resolved = m_tdata[SW + RB +: RB];

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Requests are taken only when the result register frees up.
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("request taken while a result is stalled");

    // Only a hit carries a closure, and a hit always has a nonzero class.
    a_hit_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (w_status == mdc_pkg::STAT_HIT) |-> (w_resolved != '0))
        else $error("hit reported with zero class");

    a_closure_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (w_status != mdc_pkg::STAT_HIT) |-> (w_closure == '0))
        else $error("closure returned without a hit");

    // The tag clearing walk blocks requests right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_tready)
        else $error("request taken during tag clearing");

endmodule

bind method_dispatch_cache mdc_chk u_mdc_chk (.*);

`default_nettype wire
